// ===== design/escaped_integer_huffman_encoder_core_macros.svh =====
// assertion macros shared by the encoder core modules
`ifndef ESCAPED_INTEGER_HUFFMAN_ENCODER_CORE_MACROS_SVH
`define ESCAPED_INTEGER_HUFFMAN_ENCODER_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define EIHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true out of reset
`define EIHE_ASSERT_NEVER(lbl, cond, msg) \
  `EIHE_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/eihe_pkg.sv =====
// types and constants of the escaped integer huffman encoder
`default_nettype none

package eihe_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam int IDX_W  = 9;
  localparam int CODE_W = 15;
  localparam int LEN_W  = 4;
  localparam int VAL_W  = 32;
  localparam int ENT_W  = CODE_W + LEN_W;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ENC  = 2'd1;
  localparam logic [1:0] REQ_EOT  = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [1:0] CFG_ESC2 = 2'd0;
  localparam logic [1:0] CFG_ESCB = 2'd1;
  localparam logic [1:0] CFG_NULL = 2'd2;
  localparam logic [1:0] CFG_EOT  = 2'd3;

  localparam logic [IDX_W-1:0] ESC2_RST = 9'd256;
  localparam logic [IDX_W-1:0] ESCB_RST = 9'd257;
  localparam logic [IDX_W-1:0] NULL_RST = 9'd258;
  localparam logic [IDX_W-1:0] EOT_RST  = 9'd259;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_ENC,
    KIND_EOT
  } kind_t;

  typedef enum logic [2:0] {
    CLS_B8,
    CLS_B10,
    CLS_B12,
    CLS_B14,
    CLS_B16,
    CLS_NULL,
    CLS_B24,
    CLS_B32
  } cls_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        entry_index;
    logic [CODE_W-1:0]       entry_code;
    logic [LEN_W-1:0]        entry_length;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] chunk_bits;
    logic [LEN_W-1:0]  chunk_length;
    logic              chunk_is_payload;
    logic              last;
  } out_item_t;

  typedef struct packed {
    kind_t             kind;
    cls_t              cls;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  entry_index;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_length;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

`default_nettype wire

// ===== design/eihe_front.sv =====
// front end: accepts input items, classifies them and queues commands
`default_nettype none
`include "escaped_integer_huffman_encoder_core_macros.svh"

module eihe_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire eihe_pkg::in_item_t in_item,
  output eihe_pkg::head_t        head,
  input  wire logic              cmd_pop
);

  localparam int CQ_DEPTH = eihe_pkg::CQ_DEPTH;
  localparam int CQ_AW    = eihe_pkg::CQ_AW;
  localparam int CQ_CW    = eihe_pkg::CQ_CW;

  eihe_pkg::cmd_t   cq_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cq_cnt_r, cq_cnt_nxt;

  logic             accepted;
  logic             enq;
  logic [31:0]      v;
  logic             f8, f10, f12, f14, f16, f24, is_min;
  eihe_pkg::cmd_t   new_cmd;

  assign v = in_item.value;

  // range of the value by sign-extension checks
  always_comb begin
    f8     = (v[31:7]  == {25{v[31]}});
    f10    = (v[31:9]  == {23{v[31]}});
    f12    = (v[31:11] == {21{v[31]}});
    f14    = (v[31:13] == {19{v[31]}});
    f16    = (v[31:15] == {17{v[31]}});
    f24    = (v[31:23] == {9{v[31]}});
    is_min = (v == 32'h8000_0000);
  end

  always_comb begin
    new_cmd.value        = v;
    new_cmd.entry_index  = in_item.entry_index;
    new_cmd.entry_code   = in_item.entry_code;
    new_cmd.entry_length = in_item.entry_length;
    case (in_item.req_type)
      eihe_pkg::REQ_LOAD: new_cmd.kind = eihe_pkg::KIND_LOAD;
      eihe_pkg::REQ_EOT:  new_cmd.kind = eihe_pkg::KIND_EOT;
      default:            new_cmd.kind = eihe_pkg::KIND_ENC;
    endcase
    if (f8) begin
      new_cmd.cls = eihe_pkg::CLS_B8;
    end else if (f10) begin
      new_cmd.cls = eihe_pkg::CLS_B10;
    end else if (f12) begin
      new_cmd.cls = eihe_pkg::CLS_B12;
    end else if (f14) begin
      new_cmd.cls = eihe_pkg::CLS_B14;
    end else if (f16) begin
      new_cmd.cls = eihe_pkg::CLS_B16;
    end else if (is_min) begin
      new_cmd.cls = eihe_pkg::CLS_NULL;
    end else if (f24) begin
      new_cmd.cls = eihe_pkg::CLS_B24;
    end else begin
      new_cmd.cls = eihe_pkg::CLS_B32;
    end
  end

  assign in_full  = (cq_cnt_r == CQ_CW'(CQ_DEPTH));
  assign accepted = in_push && !in_full;
  // reserved request type is dropped here
  assign enq      = accepted && (in_item.req_type != eihe_pkg::REQ_NONE);

  assign head.valid = (cq_cnt_r != '0);
  assign head.cmd   = cq_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + CQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + CQ_AW'(1) : rd_ptr_r;
    cq_cnt_nxt = cq_cnt_r + CQ_CW'(enq) - CQ_CW'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cq_cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cq_cnt_r <= cq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      cq_r[wr_ptr_r] <= new_cmd;
    end
  end

  `EIHE_ASSERT(a_cq_bound, cq_cnt_r <= CQ_CW'(CQ_DEPTH), "command queue count out of range")
  `EIHE_ASSERT_NEVER(a_pop_empty, cmd_pop && (cq_cnt_r == '0), "command popped from empty queue")
  `EIHE_ASSERT(a_enq_lands, (enq && !cmd_pop) |=> (cq_cnt_r == $past(cq_cnt_r) + 1'b1), "command lost on enqueue")

endmodule

`default_nettype wire

// ===== design/eihe_back.sv =====
// back end: config registers, code table, chunk sequencer and result queue
`default_nettype none
`include "escaped_integer_huffman_encoder_core_macros.svh"

module eihe_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire eihe_pkg::head_t     head,
  output logic                     cmd_pop,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [8:0]          cfg_data,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output eihe_pkg::out_item_t      out_chunk
);

  localparam int AW       = eihe_pkg::TBL_AW;
  localparam int DEPTH    = eihe_pkg::TABLE_DEPTH;
  localparam int IDX_W    = eihe_pkg::IDX_W;
  localparam int ENT_W    = eihe_pkg::ENT_W;
  localparam int CODE_W   = eihe_pkg::CODE_W;
  localparam int LEN_W    = eihe_pkg::LEN_W;
  localparam int OQ_DEPTH = eihe_pkg::OQ_DEPTH;
  localparam int OQ_AW    = eihe_pkg::OQ_AW;
  localparam int OQ_CW    = eihe_pkg::OQ_CW;

  // configuration registers
  logic [IDX_W-1:0] esc2_r, esc2_nxt;
  logic [IDX_W-1:0] escb_r, escb_nxt;
  logic [IDX_W-1:0] null_r, null_nxt;
  logic [IDX_W-1:0] eot_r,  eot_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    esc2_nxt = esc2_r;
    escb_nxt = escb_r;
    null_nxt = null_r;
    eot_nxt  = eot_r;
    if (cfg_valid) begin
      case (cfg_index)
        eihe_pkg::CFG_ESC2: esc2_nxt = cfg_data;
        eihe_pkg::CFG_ESCB: escb_nxt = cfg_data;
        eihe_pkg::CFG_NULL: null_nxt = cfg_data;
        eihe_pkg::CFG_EOT:  eot_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc2_r <= eihe_pkg::ESC2_RST;
      escb_r <= eihe_pkg::ESCB_RST;
      null_r <= eihe_pkg::NULL_RST;
      eot_r  <= eihe_pkg::EOT_RST;
    end else begin
      esc2_r <= esc2_nxt;
      escb_r <= escb_nxt;
      null_r <= null_nxt;
      eot_r  <= eot_nxt;
    end
  end

  // sequencer over the chunks of the head command
  eihe_pkg::cmd_t   cmd;
  logic [2:0]       step_r, step_nxt;
  logic [2:0]       nchunks;
  logic             last_step;
  logic [7:0]       base_byte;
  logic             esc2_cls;
  logic [4:0]       sh2, sh8, pos2, posb;
  logic [1:0]       pay2;
  logic [7:0]       payb;
  logic [IDX_W-1:0] code_idx;
  logic             is_code;
  logic             credit_ok;
  logic             go_emit, go_load;
  logic             ld_ok, rd_ok;

  logic [OQ_CW-1:0] oq_cnt_r, oq_cnt_nxt;
  logic             s2_valid_r;

  assign cmd = head.cmd;

  always_comb begin
    nchunks   = 3'd1;
    base_byte = cmd.value[7:0];
    esc2_cls  = 1'b0;
    sh2       = 5'd0;
    sh8       = 5'd0;
    case (cmd.cls)
      eihe_pkg::CLS_B8: begin
        base_byte = cmd.value[7:0];
      end
      eihe_pkg::CLS_B10: begin
        nchunks = 3'd3; base_byte = cmd.value[9:2]; esc2_cls = 1'b1; sh2 = 5'd2;
      end
      eihe_pkg::CLS_B12: begin
        nchunks = 3'd5; base_byte = cmd.value[11:4]; esc2_cls = 1'b1; sh2 = 5'd4;
      end
      eihe_pkg::CLS_B14: begin
        nchunks = 3'd7; base_byte = cmd.value[13:6]; esc2_cls = 1'b1; sh2 = 5'd6;
      end
      eihe_pkg::CLS_B16: begin
        nchunks = 3'd3; base_byte = cmd.value[15:8]; sh8 = 5'd8;
      end
      eihe_pkg::CLS_B24: begin
        nchunks = 3'd5; base_byte = cmd.value[23:16]; sh8 = 5'd16;
      end
      eihe_pkg::CLS_B32: begin
        nchunks = 3'd7; base_byte = cmd.value[31:24]; sh8 = 5'd24;
      end
      default: begin
        nchunks = 3'd1;
      end
    endcase
    if (cmd.kind != eihe_pkg::KIND_ENC) begin
      nchunks = 3'd1;
    end
  end

  always_comb begin
    last_step = (step_r == nchunks - 3'd1);
    pos2      = sh2 - {2'b00, step_r};
    posb      = sh8 - {step_r, 2'b00};
    pay2      = 2'(cmd.value >> pos2);
    payb      = 8'(cmd.value >> posb);
    is_code   = (cmd.kind == eihe_pkg::KIND_EOT) || (step_r == 3'd0) || step_r[0];
    if (cmd.kind == eihe_pkg::KIND_EOT) begin
      code_idx = eot_r;
    end else if (step_r == 3'd0) begin
      code_idx = (cmd.cls == eihe_pkg::CLS_NULL) ? null_r : {1'b0, base_byte ^ 8'h80};
    end else begin
      code_idx = esc2_cls ? esc2_r : escb_r;
    end
  end

  always_comb begin
    credit_ok = ((OQ_CW+1)'(oq_cnt_r) + (OQ_CW+1)'(s2_valid_r)) < (OQ_CW+1)'(OQ_DEPTH);
    go_load   = head.valid && (cmd.kind == eihe_pkg::KIND_LOAD);
    go_emit   = head.valid && (cmd.kind != eihe_pkg::KIND_LOAD) && credit_ok;
    cmd_pop   = go_load || (go_emit && last_step);
    step_nxt  = step_r;
    if (go_emit) begin
      step_nxt = last_step ? 3'd0 : step_r + 3'd1;
    end
    ld_ok = (32'(cmd.entry_index) < 32'(DEPTH));
    rd_ok = (32'(code_idx) < 32'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  // code table
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (go_load && ld_ok) begin
      mem[AW'(cmd.entry_index)] <= {cmd.entry_length, cmd.entry_code};
    end
    if (go_emit && is_code) begin
      rdata_r <= mem[AW'(code_idx)];
    end
  end

  // chunk assembly stage
  logic       s2_code_r, s2_oob_r, s2_last_r, s2_wide_r;
  logic [7:0] s2_pbits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= go_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (go_emit) begin
      s2_code_r  <= is_code;
      s2_oob_r   <= !rd_ok;
      s2_last_r  <= last_step;
      s2_wide_r  <= !esc2_cls;
      s2_pbits_r <= esc2_cls ? {6'b0, pay2} : payb;
    end
  end

  eihe_pkg::out_item_t s2_chunk;

  always_comb begin
    s2_chunk.last = s2_last_r;
    if (s2_code_r) begin
      s2_chunk.chunk_is_payload = 1'b0;
      s2_chunk.chunk_bits       = s2_oob_r ? '0 : rdata_r[CODE_W-1:0];
      s2_chunk.chunk_length     = s2_oob_r ? '0 : rdata_r[ENT_W-1:CODE_W];
    end else begin
      s2_chunk.chunk_is_payload = 1'b1;
      s2_chunk.chunk_bits       = {7'b0, s2_pbits_r};
      s2_chunk.chunk_length     = s2_wide_r ? LEN_W'(8) : LEN_W'(2);
    end
  end

  // result queue
  eihe_pkg::out_item_t oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]    oq_wr_r, oq_wr_nxt;
  logic [OQ_AW-1:0]    oq_rd_r, oq_rd_nxt;
  logic                oq_pop;

  assign out_empty = (oq_cnt_r == '0);
  assign out_chunk = oq_r[oq_rd_r];
  assign oq_pop    = out_pop && !out_empty;

  always_comb begin
    oq_wr_nxt  = s2_valid_r ? oq_wr_r + OQ_AW'(1) : oq_wr_r;
    oq_rd_nxt  = oq_pop ? oq_rd_r + OQ_AW'(1) : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r + OQ_CW'(s2_valid_r) - OQ_CW'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      oq_r[oq_wr_r] <= s2_chunk;
    end
  end

  `EIHE_ASSERT(a_oq_bound, oq_cnt_r <= OQ_CW'(OQ_DEPTH), "result queue count out of range")
  `EIHE_ASSERT_NEVER(a_oq_overrun, s2_valid_r && (oq_cnt_r == OQ_CW'(OQ_DEPTH)), "chunk pushed into full result queue")
  `EIHE_ASSERT(a_step_in_item, (step_r != 3'd0) |-> (head.valid && (head.cmd.kind == eihe_pkg::KIND_ENC)), "sequencer mid item without an encode command")
  `EIHE_ASSERT(a_pop_rewinds, cmd_pop |=> (step_r == 3'd0), "sequencer step not cleared after command")

endmodule

`default_nettype wire

// ===== design/escaped_integer_huffman_encoder_core.sv =====
// top level of the escaped integer huffman encoder core
// Encodes signed 32-bit values into Huffman code chunks and raw escape payloads, one
// chunk per cycle on the result queue while it has room. An item produces one chunk
// for a value in -128..127, INT_MIN or an end item, three for 10- and 16-bit values,
// five for 12- and 24-bit values and seven for 14- and 32-bit values, set by the chunk
// sequencer that issues one table read or payload per cycle while the result queue has
// room. A load item writes the code table and produces nothing. Input and output
// decouple through a two-entry command queue and a four-entry result queue; a chunk
// passes the table read and chunk assembly registers on its way into the result queue.
// The code table has no reset: every entry an item refers to must be loaded first.
// Configuration is accepted at any cycle but must only be written while the block is idle.
`default_nettype none

module escaped_integer_huffman_encoder_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire eihe_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output eihe_pkg::out_item_t      out_chunk,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [8:0]          cfg_data
);

  eihe_pkg::head_t head;
  logic            cmd_pop;

  eihe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .head    (head),
    .cmd_pop (cmd_pop)
  );

  eihe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_chunk (out_chunk)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the escaped integer huffman encoder core
`timescale 1ns / 100ps

module tb;
  import eihe_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  in_item_t            in_item;
  logic                out_empty;
  logic                out_pop;
  out_item_t           out_chunk;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [IDX_W-1:0]    cfg_data;

  // predictor state
  logic [ENT_W-1:0]    code_tbl [TABLE_DEPTH];
  logic [IDX_W-1:0]    esc2_idx;
  logic [IDX_W-1:0]    escb_idx;
  logic [IDX_W-1:0]    null_idx;
  logic [IDX_W-1:0]    eot_idx;
  out_item_t           chunk_q [$];

  int                  mismatch_cnt;
  int                  send_idle_pct;
  int                  pop_idle_pct;
  logic                rcv_stall;
  event                hold_go;

  escaped_integer_huffman_encoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_chunk (out_chunk),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic out_item_t table_chunk(input logic [IDX_W-1:0] idx);
    out_item_t c;
    c.chunk_bits       = code_tbl[idx][CODE_W-1:0];
    c.chunk_length     = code_tbl[idx][ENT_W-1:CODE_W];
    c.chunk_is_payload = 1'b0;
    c.last             = 1'b0;
    return c;
  endfunction

  function automatic out_item_t payload_chunk(input logic [VAL_W-1:0] bits, input int len);
    out_item_t c;
    c.chunk_bits       = bits[CODE_W-1:0];
    c.chunk_length     = len[LEN_W-1:0];
    c.chunk_is_payload = 1'b1;
    c.last             = 1'b0;
    return c;
  endfunction

  function automatic int value_width(input int s);
    if (s >= -128 && s <= 127) return 8;
    if (s >= -512 && s <= 511) return 10;
    if (s >= -2048 && s <= 2047) return 12;
    if (s >= -8192 && s <= 8191) return 14;
    if (s >= -32768 && s <= 32767) return 16;
    if (s >= -8388608 && s <= 8388607) return 24;
    return 32;
  endfunction

  // updates the table copy or queues the chunks that one transaction produces
  function automatic void predict_chunks(input in_item_t it);
    out_item_t        seq [7];
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] pay;
    logic [7:0]       top;
    int               n;
    int               w;
    int               step;
    int               k;
    v = it.value;
    n = 0;
    if (it.req_type == REQ_LOAD) begin
      code_tbl[it.entry_index] = {it.entry_length, it.entry_code};
    end else if (it.req_type == REQ_EOT) begin
      seq[0] = table_chunk(eot_idx);
      n = 1;
    end else if (it.req_type == REQ_ENC) begin
      if (v == 32'h8000_0000) begin
        seq[0] = table_chunk(null_idx);
        n = 1;
      end else begin
        w = value_width(it.value);
        step = (w <= 14) ? 2 : 8;
        top = v >> (w - 8);
        seq[0] = table_chunk({1'b0, top ^ 8'h80});
        n = 1;
        for (k = w - 8; k > 0; k = k - step) begin
          pay = v >> (k - step);
          pay = (step == 2) ? (pay & 32'h3) : (pay & 32'hFF);
          seq[n] = table_chunk((step == 2) ? esc2_idx : escb_idx);
          seq[n + 1] = payload_chunk(pay, step);
          n = n + 2;
        end
      end
    end
    if (n > 0) begin
      seq[n - 1].last = 1'b1;
      for (k = 0; k < n; k++) chunk_q.push_back(seq[k]);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (chunk_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected chunk bits=%h len=%0d payload=%b last=%b", $realtime,
                   out_chunk.chunk_bits, out_chunk.chunk_length,
                   out_chunk.chunk_is_payload, out_chunk.last);
      end else begin
        e = chunk_q.pop_front();
        if (out_chunk.chunk_bits !== e.chunk_bits ||
            out_chunk.chunk_length !== e.chunk_length ||
            out_chunk.chunk_is_payload !== e.chunk_is_payload ||
            out_chunk.last !== e.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: expected bits=%h len=%0d payload=%b last=%b, got bits=%h len=%0d payload=%b last=%b",
                     $realtime, e.chunk_bits, e.chunk_length, e.chunk_is_payload, e.last,
                     out_chunk.chunk_bits, out_chunk.chunk_length,
                     out_chunk.chunk_is_payload, out_chunk.last);
        end
      end
    end
  end

  // result side pop driver
  always @(posedge clk) begin
    if (!rst_n || rcv_stall) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // long receiver hold-off
  always begin
    @(hold_go);
    rcv_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rcv_stall <= 1'b0;
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_chunks(it);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [IDX_W-1:0] r_esc2, input logic [IDX_W-1:0] r_escb,
                          input logic [IDX_W-1:0] r_null, input logic [IDX_W-1:0] r_eot);
    logic [IDX_W-1:0] vals [4];
    logic [1:0]       reg_ids [4];
    int               i;
    vals = '{r_esc2, r_escb, r_null, r_eot};
    reg_ids = '{CFG_ESC2, CFG_ESCB, CFG_NULL, CFG_EOT};
    wait_idle();
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (reg_ids[i])
        CFG_ESC2: esc2_idx = vals[i];
        CFG_ESCB: escb_idx = vals[i];
        CFG_NULL: null_idx = vals[i];
        default:  eot_idx  = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(input logic [1:0] req, input logic [VAL_W-1:0] val);
    in_item_t it;
    it.req_type     = req;
    it.entry_index  = $urandom_range(TABLE_DEPTH - 1);
    it.entry_code   = $urandom_range(32767);
    it.entry_length = $urandom_range(15);
    it.value        = val;
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] random_value(input int w);
    logic [VAL_W-1:0] raw;
    int               sh;
    raw = $urandom;
    sh  = 32 - w;
    return $signed(raw << sh) >>> sh;
  endfunction

  // every entry gets written so that any index can be read later
  task automatic test_table_load();
    in_item_t it;
    int       i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      it = make_item(REQ_LOAD, $urandom);
      it.entry_index = i;
      if (i == 0) begin
        it.entry_code = '0;
        it.entry_length = '0;
      end else if (i == 1 || i == 511) begin
        it.entry_code = '1;
        it.entry_length = '1;
      end
      send_item(it);
    end
  endtask

  task automatic test_reset_registers();
    send_item(make_item(REQ_ENC, 300));
    send_item(make_item(REQ_ENC, -30000));
    send_item(make_item(REQ_ENC, 32'h8000_0000));
    send_item(make_item(REQ_EOT, $urandom));
  endtask

  task automatic test_range_limits();
    int lims [20];
    int i;
    lims = '{0, -1, 127, -128, 128, -129, 511, -512, 2047, -2048, 8191, -8192,
             32767, -32768, 8388607, -8388608, 8388608, -8388609, 2147483647, -2147483647};
    for (i = 0; i < 20; i++) send_item(make_item(REQ_ENC, lims[i]));
  endtask

  task automatic test_special_items();
    in_item_t it;
    send_item(make_item(REQ_ENC, 32'h8000_0000));
    send_item(make_item(REQ_EOT, 32'h8000_0000));
    send_item(make_item(REQ_NONE, $urandom));
    send_item(make_item(REQ_NONE, 32'h8000_0000));
    it = make_item(REQ_LOAD, $urandom);
    it.entry_index = 9'd255;
    it.entry_code = '1;
    it.entry_length = '1;
    send_item(it);
    send_item(make_item(REQ_ENC, 127));
    it.entry_index = 9'd0;
    it.entry_code = '0;
    it.entry_length = '0;
    send_item(it);
    send_item(make_item(REQ_ENC, -128));
    send_item(make_item(REQ_EOT, 0));
  endtask

  task automatic register_probe();
    send_item(make_item(REQ_ENC, 300));
    send_item(make_item(REQ_ENC, -5000));
    send_item(make_item(REQ_ENC, 20000));
    send_item(make_item(REQ_ENC, 32'h8000_0000));
    send_item(make_item(REQ_ENC, -2000000000));
    send_item(make_item(REQ_EOT, $urandom));
  endtask

  task automatic test_register_settings();
    set_regs('0, '0, '0, '0);
    register_probe();
    set_regs('1, '1, '1, '1);
    register_probe();
    set_regs(9'd0, 9'd511, 9'd1, 9'd128);
    register_probe();
    set_regs($urandom, $urandom, $urandom, $urandom);
    register_probe();
  endtask

  task automatic random_batch(input int count);
    in_item_t it;
    int       widths [7];
    int       r;
    widths = '{8, 10, 12, 14, 16, 24, 32};
    repeat (count) begin
      r = $urandom_range(99);
      it = make_item(REQ_ENC, $urandom);
      if (r < 10) begin
        it.req_type = REQ_LOAD;
      end else if (r < 20) begin
        it.req_type = REQ_EOT;
      end else if (r < 24) begin
        it.req_type = REQ_NONE;
      end else if (r < 28) begin
        it.value = 32'h8000_0000;
      end else begin
        it.value = random_value(widths[$urandom_range(6)]);
      end
      send_item(it);
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 38;
    pop_idle_pct  = 74;
    random_batch(57);
    set_regs($urandom, $urandom, $urandom, $urandom);
    send_idle_pct = 74;
    pop_idle_pct  = 38;
    random_batch(57);
    set_regs(ESC2_RST, ESCB_RST, NULL_RST, EOT_RST);
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    random_batch(57);
  endtask

  // receiver stops for a long stretch while the sender keeps offering wide values
  task automatic test_backpressure();
    int i;
    wait_idle();
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    -> hold_go;
    for (i = 0; i < 24; i++) send_item(make_item(REQ_ENC, random_value(32) | 32'h4000_0000));
  endtask

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_item      = '0;
    out_pop      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ESC2;
    cfg_data     = '0;
    rcv_stall    = 1'b0;
    mismatch_cnt = 0;
    esc2_idx     = ESC2_RST;
    escb_idx     = ESCB_RST;
    null_idx     = NULL_RST;
    eot_idx      = EOT_RST;
    send_idle_pct = 38;
    pop_idle_pct  = 74;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_load();
    test_reset_registers();
    test_range_limits();
    test_special_items();
    test_register_settings();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    if (mismatch_cnt == 0 && chunk_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

endmodule
